>>> design/button_debounce_lockout_defines.svh
// Assertion macros shared by the button debounce design.
// Depends on clk_i and rst_ni being present in the module that uses them.
`ifndef BUTTON_DEBOUNCE_LOCKOUT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LOCKOUT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define BDL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bdl check failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset
`define BDL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bdl check failed: next-cycle implication");

`endif

>>> design/bdl_pkg.sv
// Package for the button debounce/lockout block: widths, register codes,
// reset values and the lane structs. No dependencies.
`timescale 1ns / 1ps

package bdl_pkg;

  // Fixed port widths
  localparam int unsigned BUTTONS_IO = 8;
  localparam int unsigned DEBOUNCE_W = 20;
  localparam int unsigned LOCKOUT_W  = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;

  // Parameter defaults
  localparam int unsigned BUTTON_COUNT_DEF = 8;
  localparam int unsigned TIME_BITS_DEF    = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT  = 1'b1;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd1000;
  localparam logic [LOCKOUT_W-1:0]  LOCKOUT_RESET  = 24'd100000;

  // Timing settings seen by every lane
  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce;
    logic [LOCKOUT_W-1:0]  lockout;
  } lane_cfg_t;

  // Per-button result of one step
  typedef struct packed {
    logic held;
    logic pressed;
    logic released;
  } lane_out_t;

endpackage

>>> design/button_debounce_lockout.sv
// Top level of the eight-button debouncer with per-button lockout.
// Depends on bdl_pkg, bdl_lane and button_debounce_lockout_defines.svh.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o     | edge_mask_i, pin_levels_i
//  out     | out_valid_o / out_ready_i   | held_mask_o, pressed_mask_o, released_mask_o
//  cfg     | cfg_we_i (no wait)          | cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the receiver holds out_ready_i high.
// The item sits in an input register, all lanes evaluate it in parallel and
// the result register takes it together with the state update.
// Reset clears time, pending flags, stamps and held state; no clearing pass.
// When out_ready_i is low, one item waits in the input register and one in
// the result register; in_ready_o then drops until the result is taken.
`timescale 1ns / 1ps
`include "button_debounce_lockout_defines.svh"

module button_debounce_lockout #(
  parameter int unsigned BUTTON_COUNT = bdl_pkg::BUTTON_COUNT_DEF,
  parameter int unsigned TIME_BITS    = bdl_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]    edge_mask_i,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]    pin_levels_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bdl_pkg::BUTTONS_IO-1:0]    held_mask_o,
  output logic [bdl_pkg::BUTTONS_IO-1:0]    pressed_mask_o,
  output logic [bdl_pkg::BUTTONS_IO-1:0]    released_mask_o,
  input  logic                              cfg_we_i,
  input  logic [bdl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bdl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IO_W = bdl_pkg::BUTTONS_IO;

  logic                   in_vld_q;
  logic [IO_W-1:0]        edge_q;
  logic [IO_W-1:0]        level_q;
  logic                   out_vld_q;
  logic [IO_W-1:0]        held_q;
  logic [IO_W-1:0]        pressed_q;
  logic [IO_W-1:0]        released_q;
  logic [TIME_BITS-1:0]   tick_q;
  bdl_pkg::lane_cfg_t     cfg_q;

  logic                   step;
  bdl_pkg::lane_out_t     lane_out [BUTTON_COUNT];
  logic [IO_W-1:0]        held_d;
  logic [IO_W-1:0]        pressed_d;
  logic [IO_W-1:0]        released_d;

  // Handshake: the stored item moves on whenever the result slot frees up
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= bdl_pkg::DEBOUNCE_RESET;
      cfg_q.lockout  <= bdl_pkg::LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bdl_pkg::REG_DEBOUNCE: cfg_q.debounce <= cfg_wdata_i[bdl_pkg::DEBOUNCE_W-1:0];
        bdl_pkg::REG_LOCKOUT:  cfg_q.lockout  <= cfg_wdata_i[bdl_pkg::LOCKOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      edge_q  <= edge_mask_i;
      level_q <= pin_levels_i;
    end
  end

  // Tick counter, one count per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (step) begin
      tick_q <= tick_q + TIME_BITS'(1);
    end
  end

  // Button lanes; lanes beyond the port width never see an edge
  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    logic lane_edge;
    logic lane_level;
    if (i < IO_W) begin : g_io
      assign lane_edge  = edge_q[i];
      assign lane_level = level_q[i];
    end else begin : g_idle
      assign lane_edge  = 1'b0;
      assign lane_level = 1'b0;
    end

    bdl_lane #(
      .TIME_BITS (TIME_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .now_i   (tick_q),
      .edge_i  (lane_edge),
      .level_i (lane_level),
      .cfg_i   (cfg_q),
      .out_o   (lane_out[i])
    );
  end

  // Gather lane results into the port-wide masks
  for (genvar j = 0; j < IO_W; j++) begin : g_mask
    if (j < BUTTON_COUNT) begin : g_used
      assign held_d[j]     = lane_out[j].held;
      assign pressed_d[j]  = lane_out[j].pressed;
      assign released_d[j] = lane_out[j].released;
    end else begin : g_unused
      assign held_d[j]     = 1'b0;
      assign pressed_d[j]  = 1'b0;
      assign released_d[j] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      held_q     <= held_d;
      pressed_q  <= pressed_d;
      released_q <= released_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign held_mask_o     = held_q;
  assign pressed_mask_o  = pressed_q;
  assign released_mask_o = released_q;

  // Checks
  `BDL_ASSERT_NOW(a_press_release_apart, out_vld_q, (pressed_q & released_q) == '0)
  `BDL_ASSERT_NOW(a_events_match_held, out_vld_q, ((pressed_q & ~held_q) | (released_q & held_q)) == '0)
  `BDL_ASSERT_NEXT(a_tick_advances, step, tick_q == $past(tick_q) + TIME_BITS'(1))
  `BDL_ASSERT_NEXT(a_stalled_item_kept, in_vld_q && !step, in_vld_q && $stable(edge_q) && $stable(level_q))
  `BDL_ASSERT_NEXT(a_step_fills_result, step, out_vld_q)

endmodule

>>> design/bdl_lane.sv
// One button qualifier lane: pending flag, edge and accept stamps, held state.
// Depends on bdl_pkg.
`timescale 1ns / 1ps

module bdl_lane #(
  parameter int unsigned TIME_BITS = bdl_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 edge_i,
  input  logic                 level_i,
  input  bdl_pkg::lane_cfg_t   cfg_i,
  output bdl_pkg::lane_out_t   out_o
);

  localparam int unsigned CMP_W =
    (TIME_BITS > bdl_pkg::LOCKOUT_W) ? TIME_BITS : bdl_pkg::LOCKOUT_W;

  logic                 pending_q;
  logic                 held_q;
  logic [TIME_BITS-1:0] edge_stamp_q;
  logic [TIME_BITS-1:0] accept_stamp_q;

  logic [TIME_BITS-1:0] since_edge;
  logic [TIME_BITS-1:0] since_accept;
  logic                 due;
  logic                 change;
  logic                 held_d;

  // Wrapping elapsed times and the two window checks
  assign since_edge   = now_i - edge_stamp_q;
  assign since_accept = now_i - accept_stamp_q;
  assign due    = pending_q &&
                  (CMP_W'(since_edge) >= CMP_W'(cfg_i.debounce));
  assign change = due && (level_i != held_q) &&
                  (CMP_W'(since_accept) >= CMP_W'(cfg_i.lockout));
  assign held_d = change ? level_i : held_q;

  assign out_o.held     = held_d;
  assign out_o.pressed  = change & level_i;
  assign out_o.released = change & ~level_i;

  // State update: the check runs first, then this tick's edge applies
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q      <= 1'b0;
      held_q         <= 1'b0;
      edge_stamp_q   <= '0;
      accept_stamp_q <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      if (change) begin
        accept_stamp_q <= now_i;
      end
      if (edge_i) begin
        pending_q    <= 1'b1;
        edge_stamp_q <= now_i;
      end else if (due) begin
        pending_q <= 1'b0;
      end
    end
  end

endmodule

>>> tb/button_event_checker.sv
// Checker for the button debouncer: watches the item, result and register ports,
// predicts each result mask set and compares it with what comes out.
// Depends on bdl_pkg.
`timescale 1ns / 1ps

module button_event_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]      edge_mask_i,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]      pin_levels_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]      held_mask_i,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]      pressed_mask_i,
  input  logic [bdl_pkg::BUTTONS_IO-1:0]      released_mask_i,
  input  logic                                cfg_we_i,
  input  logic [bdl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bdl_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output int unsigned                         mismatch_cnt_o,
  output int unsigned                         pending_cnt_o
);

  typedef struct packed {
    logic [bdl_pkg::BUTTONS_IO-1:0] held;
    logic [bdl_pkg::BUTTONS_IO-1:0] pressed;
    logic [bdl_pkg::BUTTONS_IO-1:0] released;
  } button_masks_t;

  // Timing settings as last written
  logic [bdl_pkg::DEBOUNCE_W-1:0] debounce_len;
  logic [bdl_pkg::LOCKOUT_W-1:0]  lockout_len;

  // Per-button tracking state
  logic [31:0]                    tick_now;
  logic [bdl_pkg::BUTTONS_IO-1:0] pending_btn;
  logic [bdl_pkg::BUTTONS_IO-1:0] held_btn;
  logic [31:0]                    edge_at   [bdl_pkg::BUTTONS_IO];
  logic [31:0]                    accept_at [bdl_pkg::BUTTONS_IO];

  button_masks_t predicted_masks [$];
  int unsigned   mismatch_cnt;

  // One tick: sample settled buttons first, then take this tick's edges
  function automatic button_masks_t debounce_tick(
    input logic [bdl_pkg::BUTTONS_IO-1:0] edges,
    input logic [bdl_pkg::BUTTONS_IO-1:0] levels
  );
    button_masks_t r;
    logic [31:0]   since_edge;
    logic [31:0]   since_accept;
    r.pressed  = '0;
    r.released = '0;
    for (int b = 0; b < bdl_pkg::BUTTONS_IO; b++) begin
      since_edge   = tick_now - edge_at[b];
      since_accept = tick_now - accept_at[b];
      if (pending_btn[b] && since_edge >= {12'd0, debounce_len}) begin
        // change only outside the lockout window; pending clears either way
        if (levels[b] != held_btn[b] && since_accept >= {8'd0, lockout_len}) begin
          held_btn[b] = levels[b];
          if (levels[b]) r.pressed[b] = 1'b1;
          else r.released[b] = 1'b1;
          accept_at[b] = tick_now;
        end
        pending_btn[b] = 1'b0;
      end
    end
    for (int b = 0; b < bdl_pkg::BUTTONS_IO; b++) begin
      if (edges[b]) begin
        pending_btn[b] = 1'b1;
        edge_at[b]     = tick_now;
      end
    end
    tick_now = tick_now + 32'd1;
    r.held   = held_btn;
    return r;
  endfunction

  // Track writes, predict on accepted items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin : watch
    button_masks_t want;
    if (!rst_ni) begin
      debounce_len = bdl_pkg::DEBOUNCE_RESET;
      lockout_len  = bdl_pkg::LOCKOUT_RESET;
      tick_now     = '0;
      pending_btn  = '0;
      held_btn     = '0;
      for (int b = 0; b < bdl_pkg::BUTTONS_IO; b++) begin
        edge_at[b]   = '0;
        accept_at[b] = '0;
      end
      predicted_masks.delete();
      mismatch_cnt   = 0;
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bdl_pkg::REG_DEBOUNCE: debounce_len = cfg_wdata_i[bdl_pkg::DEBOUNCE_W-1:0];
          bdl_pkg::REG_LOCKOUT:  lockout_len  = cfg_wdata_i[bdl_pkg::LOCKOUT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (predicted_masks.size() == 0) begin
          $error("result with no item outstanding: held %h pressed %h released %h",
                 held_mask_i, pressed_mask_i, released_mask_i);
          mismatch_cnt++;
        end else begin
          want = predicted_masks.pop_front();
          if (held_mask_i !== want.held) begin
            $error("held_mask: expected %h, actual %h", want.held, held_mask_i);
            mismatch_cnt++;
          end
          if (pressed_mask_i !== want.pressed) begin
            $error("pressed_mask: expected %h, actual %h", want.pressed, pressed_mask_i);
            mismatch_cnt++;
          end
          if (released_mask_i !== want.released) begin
            $error("released_mask: expected %h, actual %h", want.released, released_mask_i);
            mismatch_cnt++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        predicted_masks.push_back(debounce_tick(edge_mask_i, pin_levels_i));
      end

      mismatch_cnt_o <= mismatch_cnt;
      pending_cnt_o  <= predicted_masks.size();
    end
  end

endmodule

>>> tb/tb_button_debounce_lockout.sv
// Testbench top for button_debounce_lockout: clock, reset, item and register
// stimulus, receiver back-pressure and the verdict. Depends on bdl_pkg,
// the design and button_event_checker.
`timescale 1ns / 1ps

module tb_button_debounce_lockout;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int          SEGMENTS    = 9;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                 in_valid    = 1'b0;
  logic                                 in_ready;
  logic [bdl_pkg::BUTTONS_IO-1:0]       edge_mask   = '0;
  logic [bdl_pkg::BUTTONS_IO-1:0]       pin_levels  = '0;
  logic                                 out_valid;
  logic                                 out_ready   = 1'b0;
  logic [bdl_pkg::BUTTONS_IO-1:0]       held_mask;
  logic [bdl_pkg::BUTTONS_IO-1:0]       pressed_mask;
  logic [bdl_pkg::BUTTONS_IO-1:0]       released_mask;
  logic                                 cfg_we      = 1'b0;
  logic [bdl_pkg::CFG_IDX_W-1:0]        cfg_idx     = bdl_pkg::REG_DEBOUNCE;
  logic [bdl_pkg::CFG_DATA_W-1:0]       cfg_wdata   = '0;

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  // Idle odds in percent; receiver odds go by nonblocking write
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  logic        hold_request = 1'b0;
  logic        hold_done    = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_cnt    = 0;

  // Random press/release model
  logic [7:0] true_lvl;
  logic [7:0] prev_pins;
  int         bounce_left [8];

  button_debounce_lockout dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .edge_mask_i    (edge_mask),
    .pin_levels_i   (pin_levels),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .held_mask_o    (held_mask),
    .pressed_mask_o (pressed_mask),
    .released_mask_o(released_mask),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata)
  );

  button_event_checker checker_i (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .edge_mask_i    (edge_mask),
    .pin_levels_i   (pin_levels),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .held_mask_i    (held_mask),
    .pressed_mask_i (pressed_mask),
    .released_mask_i(released_mask),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Offer one item, with random idle cycles in front
  task automatic send_item(input logic [7:0] edges, input logic [7:0] levels);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    edge_mask  <= edges;
    pin_levels <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Both timing registers, back to back; spare data bits get random values
  task automatic write_timing(input logic [19:0] deb, input logic [23:0] lock);
    cfg_we    <= 1'b1;
    cfg_idx   <= bdl_pkg::REG_DEBOUNCE;
    cfg_wdata <= {4'($urandom), deb};
    @(posedge clk);
    cfg_idx   <= bdl_pkg::REG_LOCKOUT;
    cfg_wdata <= lock;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [19:0] deb;
    logic [23:0] lock;
    int          n_items;
    logic [7:0]  e;
    logic [7:0]  p;

    true_lvl  = '0;
    prev_pins = '0;
    for (int b = 0; b < 8; b++) bounce_left[b] = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timing: far too long for anything to settle
    send_item(8'hFF, 8'hFF);
    send_item(8'h00, 8'h00);
    send_item(8'hFF, 8'h00);
    wait_drained();

    // Zero debounce, short lockout: start-up lockout, then a press whose release the lockout holds off
    write_timing(20'd0, 24'd6);
    send_item(8'hFF, 8'hFF);
    send_item(8'h00, 8'hFF);
    send_item(8'hFF, 8'hFF);
    send_item(8'h00, 8'hFF);
    send_item(8'hFF, 8'h00);
    send_item(8'h00, 8'h00);
    send_item(8'hAA, 8'h55);
    send_item(8'h55, 8'hAA);
    wait_drained();

    // Edge while pending restarts the wait; sample equal to held is dropped
    write_timing(20'd2, 24'd0);
    send_item(8'h01, 8'h01);
    send_item(8'h01, 8'h00);
    send_item(8'h00, 8'h00);
    send_item(8'h00, 8'h00);
    send_item(8'h0C, 8'hFF);
    send_item(8'h00, 8'hFF);
    send_item(8'h00, 8'hFF);
    send_item(8'hF0, 8'h0F);
    send_item(8'h00, 8'h0F);
    send_item(8'h00, 8'h0F);
    send_item(8'hFF, 8'hFF);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin deb = 20'd0;       lock = 24'd0;        n_items = 220; end
        1: begin deb = 20'd2;       lock = 24'd10;       n_items = 220; end
        2: begin deb = 20'hFFFFF;   lock = 24'hFFFFFF;   n_items = 30;  end
        3: begin deb = 20'd1;       lock = 24'd4;        n_items = 200; end
        4: begin deb = 20'd0;       lock = 24'hFFFFFF;   n_items = 30;  end
        5: begin deb = 20'hFFFFF;   lock = 24'd0;        n_items = 30;  end
        8: begin deb = 20'd3;       lock = 24'd0;        n_items = 250; end
        default: begin
          deb     = 20'($urandom_range(0, 6));
          lock    = 24'($urandom_range(0, 40));
          n_items = 250;
        end
      endcase

      // Sender mostly busy first, then receiver mostly busy, then no idling
      if (seg < 3) begin
        tx_idle_pct = 21;
        rx_idle_pct <= 88;
      end else if (seg < 6) begin
        tx_idle_pct = 88;
        rx_idle_pct <= 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end

      write_timing(deb, lock);
      if (seg == 6) hold_request <= 1'b1;

      for (int k = 0; k < n_items; k++) begin
        if (seg == 6 && k == 120) wait_drained();
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary edges and levels
          e = 8'($urandom);
          p = 8'($urandom);
        end else begin
          // per-button press/release with a short bounce after each change
          for (int b = 0; b < 8; b++) begin
            if (bounce_left[b] > 0) begin
              p[b] = 1'($urandom_range(0, 1));
              bounce_left[b]--;
            end else begin
              if ($urandom_range(0, 15) == 0) begin
                true_lvl[b]    = ~true_lvl[b];
                bounce_left[b] = $urandom_range(0, 4);
              end
              p[b] = true_lvl[b];
            end
          end
          e = p ^ prev_pins;
        end
        prev_pins = p;
        send_item(e, p);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> button_debounce_lockout.f
+incdir+design
design/bdl_pkg.sv
design/bdl_lane.sv
design/button_debounce_lockout.sv
tb/button_event_checker.sv
tb/tb_button_debounce_lockout.sv
